### rtl/cgt_pkg.sv
`default_nettype none

package cgt_pkg;

   localparam int FRAME_W = 4;
   localparam int NEST_W  = 6;
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [2:0] {
      FUNC_TEXT  = 3'd0,
      FUNC_OPEN  = 3'd1,
      FUNC_ELIF  = 3'd2,
      FUNC_ELSE  = 3'd3,
      FUNC_ENDIF = 3'd4,
      FUNC_OTHER = 3'd5,
      FUNC_EOF   = 3'd6
   } func_type;

   typedef enum logic [3:0] {
      ERR_NONE           = 4'd0,
      ERR_MALFORMED      = 4'd1,
      ERR_ELIF_NO_IF     = 4'd2,
      ERR_ELIF_AFTER_ELSE = 4'd3,
      ERR_ELSE_NO_IF     = 4'd4,
      ERR_DUP_ELSE       = 4'd5,
      ERR_ENDIF_NO_IF    = 4'd6,
      ERR_UNTERMINATED   = 4'd7,
      ERR_OVERFLOW       = 4'd8
   } err_type;

   typedef struct packed {
      logic branch;
      logic saw_else;
      logic taken;
      logic parent;
   } frame_type;

   typedef struct packed {
      logic      push;
      logic      pop;
      logic      clear;
      logic      wr_top;
      frame_type frame;
   } stack_op_type;

   typedef struct packed {
      logic    active;
      err_type err_code;
   } line_result_type;

endpackage

`default_nettype wire

### rtl/cgt_ram.sv
`default_nettype none

module cgt_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/cgt_frame_logic.sv
`default_nettype none

module cgt_frame_logic
   import cgt_pkg::*;
(
   input  wire logic      [2:0] func,
   input  wire logic            cond,
   input  wire logic            malformed,
   input  wire logic            empty,
   input  wire logic            full,
   input  wire frame_type       top,
   output stack_op_type         op,
   output line_result_type      result
);

   logic      region;
   logic      enclosing;
   logic      take;
   frame_type f;

   always_comb begin
      region    = empty | top.branch;
      enclosing = empty | top.parent;
      take      = region & cond & ~malformed;
      f         = top;
      op        = '0;
      result.active   = region;
      result.err_code = ERR_NONE;

      unique case (func)
         FUNC_OPEN: begin
            result.active = region;
            if (full) begin
               result.err_code = ERR_OVERFLOW;
            end else begin
               f.parent   = region;
               f.taken    = take | ~region;
               f.branch   = take;
               f.saw_else = 1'b0;
               op.push    = 1'b1;
               if (region && malformed) begin
                  result.err_code = ERR_MALFORMED;
               end
            end
         end
         FUNC_ELIF: begin
            result.active = enclosing;
            if (empty) begin
               result.err_code = ERR_ELIF_NO_IF;
            end else if (top.saw_else) begin
               result.err_code = ERR_ELIF_AFTER_ELSE;
            end else begin
               op.wr_top = 1'b1;
               if (!top.parent || top.taken || !cond) begin
                  f.branch = 1'b0;
               end else begin
                  f.taken  = 1'b1;
                  f.branch = 1'b1;
               end
            end
         end
         FUNC_ELSE: begin
            result.active = enclosing;
            if (empty) begin
               result.err_code = ERR_ELSE_NO_IF;
            end else if (top.saw_else) begin
               result.err_code = ERR_DUP_ELSE;
            end else begin
               op.wr_top  = 1'b1;
               f.branch   = top.parent & ~top.taken;
               f.saw_else = 1'b1;
               f.taken    = 1'b1;
            end
         end
         FUNC_ENDIF: begin
            result.active = enclosing;
            if (empty) begin
               result.err_code = ERR_ENDIF_NO_IF;
            end else begin
               op.pop = 1'b1;
            end
         end
         FUNC_EOF: begin
            result.active = 1'b1;
            op.clear      = 1'b1;
            if (!empty) begin
               result.err_code = ERR_UNTERMINATED;
            end
         end
         default: begin
            result.active = region;
         end
      endcase

      op.frame = f;
   end

endmodule

`default_nettype wire

### rtl/conditional_group_tracker_core.sv
// Conditional group tracker: follows if/elif/else/endif nesting of one
// preprocessed file, one classified line per request. Each request yields
// exactly one response (active flag, error code, nesting level after the
// line). Throughput is one line per clock while responses are taken; an
// accepted request goes to the input register, then response register.
// The top two frames sit in registers and deeper frames in a RAM of
// STACK_DEPTH entries whose registered read is prefetched one line ahead,
// so pushes and pops never stall. No clearing pass is needed after reset:
// only the level counter and valid/bypass flags are reset; EOF clears it.
`default_nettype none

module conditional_group_tracker_core
   import cgt_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [0] cond, [1] malformed
   input  wire logic [REQ_USER_W-1:0] req_tuser,  // [2:0] func
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata   // [0] active, [4:1] err_code,
                                                  // [10:5] nest_level
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [2:0]            func_ff;
   logic                  cond_ff;
   logic                  bad_ff;

   // stack state
   logic [CW-1:0]         count_ff, count_in;
   frame_type             top_ff, top_in;
   frame_type             below_ff, below_in;
   logic                  byp_ff, byp_in;
   frame_type             byp_data_ff;
   frame_type             deep;

   // response register
   logic                  out_valid_ff, out_valid_in;
   logic                  act_ff;
   err_type               err_ff;
   logic [NEST_W-1:0]     nest_ff;

   logic                  advance;
   logic                  empty;
   logic                  full;
   stack_op_type          op;
   line_result_type       result;
   logic [CW-1:0]         count_calc;
   logic                  ram_we;
   logic [AW-1:0]         ram_wr_addr;
   logic [AW-1:0]         ram_rd_addr;
   logic [FRAME_W-1:0]    ram_rd_data;

   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(STACK_DEPTH));

   cgt_frame_logic u_logic (
      .func      (func_ff),
      .cond      (cond_ff),
      .malformed (bad_ff),
      .empty     (empty),
      .full      (full),
      .top       (top_ff),
      .op        (op),
      .result    (result)
   );

   always_comb begin
      count_calc = count_ff;
      if (op.clear) begin
         count_calc = '0;
      end else if (op.push) begin
         count_calc = count_ff + CW'(1);
      end else if (op.pop) begin
         count_calc = count_ff - CW'(1);
      end
   end

   assign deep = byp_ff ? byp_data_ff : frame_type'(ram_rd_data);

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      below_in = below_ff;
      byp_in   = 1'b0;
      if (advance) begin
         count_in = count_calc;
         byp_in   = op.push;
         if (op.push) begin
            top_in   = op.frame;
            below_in = top_ff;
         end else if (op.pop) begin
            top_in   = below_ff;
            below_in = deep;
         end else if (op.wr_top) begin
            top_in   = op.frame;
         end
      end
   end

   // frame below the two held in registers spills to the RAM on push
   assign ram_we      = advance & op.push & ({1'b0, count_ff} >= (CW + 1)'(2));
   assign ram_wr_addr = AW'(count_ff - CW'(2));
   assign ram_rd_addr = AW'(count_in - CW'(3));

   cgt_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (below_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         byp_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         byp_ff       <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         func_ff <= req_tuser[2:0];
         cond_ff <= req_tdata[0];
         bad_ff  <= req_tdata[1];
      end
      if (advance) begin
         act_ff  <= result.active;
         err_ff  <= result.err_code;
         nest_ff <= NEST_W'(count_calc);
      end
      top_ff      <= top_in;
      below_ff    <= below_in;
      byp_data_ff <= below_ff;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 1 - 4 - NEST_W){1'b0}}, nest_ff, err_ff, act_ff};

endmodule

`default_nettype wire

### rtl/cgt_checker.sv
`default_nettype none

module cgt_checker
   import cgt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [3:0] err;
   logic [5:0] nest;
   logic       act;

   assign err  = rsp_tdata[4:1];
   assign nest = rsp_tdata[10:5];
   assign act  = rsp_tdata[0];

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // end of file always empties the stack and reports active
   a_eof_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && err == ERR_UNTERMINATED |-> nest == '0 && act)
      else $error("unterminated report with groups still open");

   // stray directives only happen on an empty stack, which is active
   a_stray_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (err == ERR_ELIF_NO_IF || err == ERR_ELSE_NO_IF ||
                     err == ERR_ENDIF_NO_IF) |-> nest == '0 && act)
      else $error("stray directive reported with open groups");

endmodule

bind conditional_group_tracker_core cgt_checker u_cgt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
